FILE: hdl/atan2_octant_lookup_angle_top_defines.svh
`ifndef ATAN2_OCTANT_LOOKUP_ANGLE_TOP_DEFINES_SVH
`define ATAN2_OCTANT_LOOKUP_ANGLE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define A2OL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define A2OL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/a2ol_pkg.sv
`default_nettype none

package a2ol_pkg;

  localparam int QUOT_WIDTH  = 9;
  localparam int ANGLE_WIDTH = 12;
  localparam int ROM_DEPTH   = 257;
  localparam int NUM_CELLS   = QUOT_WIDTH;

  localparam logic [ANGLE_WIDTH-1:0] ANG_QUARTER = 12'd512;
  localparam logic [ANGLE_WIDTH-1:0] ANG_HALF    = 12'd1024;
  localparam logic [ANGLE_WIDTH-1:0] ANG_3QUART  = 12'd1536;
  localparam logic [ANGLE_WIDTH-1:0] ANG_FULL    = 12'd2048;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic steep;
    logic zero;
  } a2ol_flags_t;

  localparam logic [QUOT_WIDTH-1:0] ATAN_ROM [0:ROM_DEPTH-1] = '{
      9'd0,   9'd1,   9'd2,   9'd3,   9'd5,   9'd6,   9'd7,   9'd8,
      9'd10,  9'd11,  9'd12,  9'd13,  9'd15,  9'd16,  9'd17,  9'd19,
      9'd20,  9'd21,  9'd22,  9'd24,  9'd25,  9'd26,  9'd27,  9'd29,
      9'd30,  9'd31,  9'd32,  9'd34,  9'd35,  9'd36,  9'd38,  9'd39,
      9'd40,  9'd41,  9'd43,  9'd44,  9'd45,  9'd46,  9'd48,  9'd49,
      9'd50,  9'd51,  9'd53,  9'd54,  9'd55,  9'd56,  9'd57,  9'd59,
      9'd60,  9'd61,  9'd62,  9'd64,  9'd65,  9'd66,  9'd67,  9'd68,
      9'd70,  9'd71,  9'd72,  9'd73,  9'd75,  9'd76,  9'd77,  9'd78,
      9'd79,  9'd81,  9'd82,  9'd83,  9'd84,  9'd85,  9'd87,  9'd88,
      9'd89,  9'd90,  9'd91,  9'd92,  9'd94,  9'd95,  9'd96,  9'd97,
      9'd98,  9'd99,  9'd101, 9'd102, 9'd103, 9'd104, 9'd105, 9'd106,
      9'd107, 9'd109, 9'd110, 9'd111, 9'd112, 9'd113, 9'd114, 9'd115,
      9'd116, 9'd118, 9'd119, 9'd120, 9'd121, 9'd122, 9'd123, 9'd124,
      9'd125, 9'd126, 9'd127, 9'd129, 9'd130, 9'd131, 9'd132, 9'd133,
      9'd134, 9'd135, 9'd136, 9'd137, 9'd138, 9'd139, 9'd140, 9'd141,
      9'd142, 9'd143, 9'd144, 9'd145, 9'd147, 9'd148, 9'd149, 9'd150,
      9'd151, 9'd152, 9'd153, 9'd154, 9'd155, 9'd156, 9'd157, 9'd158,
      9'd159, 9'd160, 9'd161, 9'd162, 9'd163, 9'd164, 9'd165, 9'd166,
      9'd167, 9'd167, 9'd168, 9'd169, 9'd170, 9'd171, 9'd172, 9'd173,
      9'd174, 9'd175, 9'd176, 9'd177, 9'd178, 9'd179, 9'd180, 9'd181,
      9'd182, 9'd182, 9'd183, 9'd184, 9'd185, 9'd186, 9'd187, 9'd188,
      9'd189, 9'd190, 9'd191, 9'd191, 9'd192, 9'd193, 9'd194, 9'd195,
      9'd196, 9'd197, 9'd198, 9'd198, 9'd199, 9'd200, 9'd201, 9'd202,
      9'd203, 9'd203, 9'd204, 9'd205, 9'd206, 9'd207, 9'd208, 9'd208,
      9'd209, 9'd210, 9'd211, 9'd212, 9'd212, 9'd213, 9'd214, 9'd215,
      9'd216, 9'd216, 9'd217, 9'd218, 9'd219, 9'd220, 9'd220, 9'd221,
      9'd222, 9'd223, 9'd223, 9'd224, 9'd225, 9'd226, 9'd226, 9'd227,
      9'd228, 9'd229, 9'd229, 9'd230, 9'd231, 9'd232, 9'd232, 9'd233,
      9'd234, 9'd235, 9'd235, 9'd236, 9'd237, 9'd237, 9'd238, 9'd239,
      9'd239, 9'd240, 9'd241, 9'd242, 9'd242, 9'd243, 9'd244, 9'd244,
      9'd245, 9'd246, 9'd246, 9'd247, 9'd248, 9'd248, 9'd249, 9'd250,
      9'd250, 9'd251, 9'd252, 9'd252, 9'd253, 9'd254, 9'd254, 9'd255,
      9'd256
  };

endpackage

`default_nettype wire

FILE: hdl/a2ol_front.sv
`default_nettype none

module a2ol_front #(
  parameter int W = 24
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [W-1:0]      coord_x,
  input  wire logic signed [W-1:0]      coord_y,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output a2ol_pkg::a2ol_flags_t         out_flags,
  output logic [W-1:0]                  out_large,
  output logic [W:0]                    out_rem,
  output logic [a2ol_pkg::QUOT_WIDTH-1:0] out_quot
);
  import a2ol_pkg::*;

  logic [W-1:0] raw_x, raw_y;
  logic [W-1:0] mag_x, mag_y;
  logic         neg_x, neg_y, steep;
  logic         valid;

  assign raw_x = coord_x;
  assign raw_y = coord_y;
  assign neg_x = raw_x[W-1];
  assign neg_y = raw_y[W-1];
  // The most negative code negates to 2^(W-1), still exact as unsigned.
  assign mag_x = neg_x ? (~raw_x + {{(W-1){1'b0}}, 1'b1}) : raw_x;
  assign mag_y = neg_y ? (~raw_y + {{(W-1){1'b0}}, 1'b1}) : raw_y;
  assign steep = mag_x < mag_y;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_flags.neg_x <= neg_x;
      out_flags.neg_y <= neg_y;
      out_flags.steep <= steep;
      out_flags.zero  <= (mag_x == '0) && (mag_y == '0);
      out_large       <= steep ? mag_y : mag_x;
      out_rem         <= {1'b0, (steep ? mag_x : mag_y)};
      out_quot        <= '0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/a2ol_div_cell.sv
`default_nettype none
`include "atan2_octant_lookup_angle_top_defines.svh"

module a2ol_div_cell #(
  parameter int W = 24
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire a2ol_pkg::a2ol_flags_t      in_flags,
  input  wire logic [W-1:0]               in_large,
  input  wire logic [W:0]                 in_rem,
  input  wire logic [a2ol_pkg::QUOT_WIDTH-1:0] in_quot,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output a2ol_pkg::a2ol_flags_t           out_flags,
  output logic [W-1:0]                    out_large,
  output logic [W:0]                      out_rem,
  output logic [a2ol_pkg::QUOT_WIDTH-1:0] out_quot
);
  import a2ol_pkg::*;

  logic [W:0] divisor, diff, kept;
  logic       fits;
  logic       valid;

  // One restoring step: trial subtract, keep or restore, shift for the next bit.
  assign divisor = {1'b0, in_large};
  assign fits    = in_rem >= divisor;
  assign diff    = in_rem - divisor;
  assign kept    = fits ? diff : in_rem;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_flags <= in_flags;
      out_large <= in_large;
      out_rem   <= {kept[W-1:0], 1'b0};
      out_quot  <= {in_quot[QUOT_WIDTH-2:0], fits};
    end
  end

  `A2OL_ASSERT_NOW(a_rem_bound, valid && !out_flags.zero, out_rem < {out_large, 1'b0}, "remainder exceeds twice the divisor")
  `A2OL_ASSERT_NEXT(a_hold_valid, valid && !out_ready, valid, "stalled cell dropped its beat")
  `A2OL_ASSERT_NEXT(a_hold_quot, valid && !out_ready, $stable(out_quot) && $stable(out_rem), "stalled cell changed its beat")

endmodule

`default_nettype wire

FILE: hdl/a2ol_back.sv
`default_nettype none

module a2ol_back (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire a2ol_pkg::a2ol_flags_t       in_flags,
  input  wire logic [a2ol_pkg::QUOT_WIDTH-1:0] in_quot,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [a2ol_pkg::ANGLE_WIDTH-1:0] angle
);
  import a2ol_pkg::*;

  logic [ANGLE_WIDTH-1:0] f, angle_next;
  logic                   valid;

  assign f = {{(ANGLE_WIDTH-QUOT_WIDTH){1'b0}}, ATAN_ROM[in_quot]};

  always_comb begin
    if (in_flags.zero) begin
      angle_next = '0;
    end else if (in_flags.neg_x) begin
      if (in_flags.neg_y) begin
        angle_next = in_flags.steep ? (ANG_FULL - f) : (ANG_3QUART + f);
      end else begin
        angle_next = in_flags.steep ? (ANG_HALF + f) : (ANG_3QUART - f);
      end
    end else begin
      if (in_flags.neg_y) begin
        angle_next = in_flags.steep ? f : (ANG_QUARTER - f);
      end else begin
        angle_next = in_flags.steep ? (ANG_HALF - f) : (ANG_QUARTER + f);
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      angle <= angle_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/atan2_octant_lookup_angle_top.sv
// Pipeline from input beat to result beat: magnitude stage, nine
// divider cells, one per quotient bit, then ROM and octant stage.
// Throughput: one vector per cycle; each stage holds one beat and moves on
// whenever the stage after it is empty or moving.
// Reset: synchronous, clears only the stage valid bits; no other state.
`default_nettype none
`include "atan2_octant_lookup_angle_top_defines.svh"

module atan2_octant_lookup_angle_top #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]    coord_x,
  input  wire logic signed [COORD_WIDTH-1:0]    coord_y,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [a2ol_pkg::ANGLE_WIDTH-1:0]      angle
);
  import a2ol_pkg::*;

  localparam int W = COORD_WIDTH;

  logic                  c_valid [0:NUM_CELLS];
  logic                  c_ready [0:NUM_CELLS];
  a2ol_flags_t           c_flags [0:NUM_CELLS];
  logic [W-1:0]          c_large [0:NUM_CELLS];
  logic [W:0]            c_rem   [0:NUM_CELLS];
  logic [QUOT_WIDTH-1:0] c_quot  [0:NUM_CELLS];

  a2ol_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .coord_x   (coord_x),
    .coord_y   (coord_y),
    .out_valid (c_valid[0]),
    .out_ready (c_ready[0]),
    .out_flags (c_flags[0]),
    .out_large (c_large[0]),
    .out_rem   (c_rem[0]),
    .out_quot  (c_quot[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    a2ol_div_cell #(.W(W)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[i]),
      .in_ready  (c_ready[i]),
      .in_flags  (c_flags[i]),
      .in_large  (c_large[i]),
      .in_rem    (c_rem[i]),
      .in_quot   (c_quot[i]),
      .out_valid (c_valid[i+1]),
      .out_ready (c_ready[i+1]),
      .out_flags (c_flags[i+1]),
      .out_large (c_large[i+1]),
      .out_rem   (c_rem[i+1]),
      .out_quot  (c_quot[i+1])
    );
  end

  a2ol_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid[NUM_CELLS]),
    .in_ready  (c_ready[NUM_CELLS]),
    .in_flags  (c_flags[NUM_CELLS]),
    .in_quot   (c_quot[NUM_CELLS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle     (angle)
  );

  // A zero vector divides by zero and leaves an all-ones quotient; its flag overrides the ROM.
  `A2OL_ASSERT_NOW(a_angle_range, out_valid, angle <= ANG_FULL, "angle beyond full turn")
  `A2OL_ASSERT_NOW(a_full_chain, !in_ready, out_valid && !out_ready, "input blocked without a stalled result")
  `A2OL_ASSERT_NOW(a_quot_range, c_valid[NUM_CELLS] && !c_flags[NUM_CELLS].zero, c_quot[NUM_CELLS] <= QUOT_WIDTH'(ROM_DEPTH - 1), "ratio index beyond ROM")

endmodule

`default_nettype wire
